>>> hdl/rld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rld_pkg;

    localparam int COORD_W       = 32;
    localparam int COEF_W        = 32;
    localparam int FRAC_BITS_DEF = 28;
    localparam int IW            = 64;
    localparam int MUL_LAT       = 5;
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_W     = 4;

    // Internal values are clamped symmetrically to this magnitude.
    localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};

    typedef enum logic [1:0] {
        ST_OK       = 2'b00,
        ST_SAT      = 2'b01,
        ST_DEN_ZERO = 2'b10
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] y_in;
    } t_pt_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        t_status                   status;
    } t_pt_out;

    typedef struct packed {
        logic signed [IW-1:0] val;
        logic                 sat;
    } t_sum;

    function automatic t_sum sadd(input logic signed [IW-1:0] a,
                                  input logic signed [IW-1:0] b);
        logic signed [IW:0] s;
        logic signed [IW:0] lim;
        t_sum               r;
        lim   = {1'b0, IMAX};
        s     = {a[IW-1], a} + {b[IW-1], b};
        r.sat = 1'b1;
        if (s > lim) begin
            r.val = IMAX;
        end else if (s < -lim) begin
            r.val = -IMAX;
        end else begin
            r.val = s[IW-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/rld_delay.sv
`timescale 1ns / 1ps
`default_nettype none
module rld_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sh [0:N-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_q = r_sh[N-1];

endmodule
`default_nettype wire

>>> hdl/rld_qmul.sv
`timescale 1ns / 1ps
`default_nettype none
module rld_qmul #(
    parameter int FRAC_BITS = rld_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [rld_pkg::IW-1:0] i_a,
    input  logic signed [rld_pkg::IW-1:0] i_b,
    output logic signed [rld_pkg::IW-1:0] o_p,
    output logic                         o_sat
);

    localparam int IW = rld_pkg::IW;
    localparam int HW = IW / 2;
    localparam logic [2*IW-1:0] HALF = (2*IW)'(1) << (FRAC_BITS - 1);

    logic [IW-1:0]   n_ma, n_mb;
    logic [IW-1:0]   r_ma, r_mb;
    logic            r_neg1, r_neg2, r_neg3, r_neg4;
    logic [IW-1:0]   r_p00, r_p01, r_p10, r_p11;
    logic [IW-1:0]   r_p00_3, r_p11_3;
    logic [IW:0]     r_mid;
    logic [2*IW-1:0] r_sum;
    logic [2*IW-1:0] w_sh;
    logic            w_sat;
    logic [IW-1:0]   w_mag;
    logic signed [IW-1:0] r_p;
    logic            r_sat;

    always_comb begin
        n_ma  = i_a[IW-1] ? (~i_a + 1'b1) : i_a;
        n_mb  = i_b[IW-1] ? (~i_b + 1'b1) : i_b;
        // Round half away from zero on the magnitude, then drop the fraction.
        w_sh  = r_sum >> FRAC_BITS;
        w_sat = |w_sh[2*IW-1:IW-1];
        w_mag = w_sat ? rld_pkg::IMAX : {1'b0, w_sh[IW-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma    <= n_ma;
            r_mb    <= n_mb;
            r_neg1  <= i_a[IW-1] ^ i_b[IW-1];
            r_p00   <= r_ma[HW-1:0]  * r_mb[HW-1:0];
            r_p01   <= r_ma[HW-1:0]  * r_mb[IW-1:HW];
            r_p10   <= r_ma[IW-1:HW] * r_mb[HW-1:0];
            r_p11   <= r_ma[IW-1:HW] * r_mb[IW-1:HW];
            r_neg2  <= r_neg1;
            r_mid   <= {1'b0, r_p01} + {1'b0, r_p10};
            r_p00_3 <= r_p00;
            r_p11_3 <= r_p11;
            r_neg3  <= r_neg2;
            r_sum   <= {r_p11_3, r_p00_3} + ({{(IW-1){1'b0}}, r_mid} << HW) + HALF;
            r_neg4  <= r_neg3;
            r_p     <= r_neg4 ? -w_mag : w_mag;
            r_sat   <= w_sat;
        end
    end

    assign o_p   = r_p;
    assign o_sat = r_sat;

endmodule
`default_nettype wire

>>> hdl/rld_qdiv.sv
`timescale 1ns / 1ps
`default_nettype none
module rld_qdiv #(
    parameter int FRAC_BITS = rld_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [rld_pkg::IW-1:0] i_num,
    input  logic signed [rld_pkg::IW-1:0] i_den,
    output logic signed [rld_pkg::IW-1:0] o_q,
    output logic                         o_sat
);

    localparam int IW = rld_pkg::IW;
    localparam int DW = IW + FRAC_BITS;

    logic [IW-1:0] w_un, w_ud;
    logic          r_neg [0:DW];
    logic [IW-1:0] r_ud  [0:DW];
    logic [IW-1:0] r_rem [0:DW];
    logic [DW-1:0] r_w   [0:DW];
    logic [IW:0]   w_t    [0:DW-1];
    logic [IW:0]   w_diff [0:DW-1];
    logic          w_ge   [0:DW-1];
    logic          w_rnd;
    logic [DW:0]   r_rq;
    logic          r_neg_r;
    logic          w_qsat;
    logic [IW-1:0] w_mag;
    logic signed [IW-1:0] r_q;
    logic          r_sat;

    // One quotient bit per stage. The shifting word holds the dividend bits
    // still to come in its upper part and the quotient bits found so far in
    // its lower part.
    always_comb begin
        w_un = i_num[IW-1] ? (~i_num + 1'b1) : i_num;
        w_ud = i_den[IW-1] ? (~i_den + 1'b1) : i_den;
        for (int k = 0; k < DW; k++) begin
            w_t[k]    = {r_rem[k], r_w[k][DW-1]};
            w_ge[k]   = w_t[k] >= {1'b0, r_ud[k]};
            w_diff[k] = w_t[k] - {1'b0, r_ud[k]};
        end
        w_rnd  = {r_rem[DW], 1'b0} >= {1'b0, r_ud[DW]};
        w_qsat = |r_rq[DW:IW-1];
        w_mag  = w_qsat ? rld_pkg::IMAX : {1'b0, r_rq[IW-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_num[IW-1] ^ i_den[IW-1];
            r_ud[0]  <= w_ud;
            r_rem[0] <= '0;
            r_w[0]   <= {w_un, {FRAC_BITS{1'b0}}};
            for (int k = 0; k < DW; k++) begin
                r_neg[k+1] <= r_neg[k];
                r_ud[k+1]  <= r_ud[k];
                r_rem[k+1] <= w_ge[k] ? w_diff[k][IW-1:0] : w_t[k][IW-1:0];
                r_w[k+1]   <= {r_w[k][DW-2:0], w_ge[k]};
            end
            r_rq    <= {1'b0, r_w[DW]} + (DW+1)'(w_rnd);
            r_neg_r <= r_neg[DW];
            r_q     <= r_neg_r ? -w_mag : w_mag;
            r_sat   <= w_qsat;
        end
    end

    assign o_q   = r_q;
    assign o_sat = r_sat;

endmodule
`default_nettype wire

>>> hdl/rational_lens_distortion.sv
`timescale 1ns / 1ps
`default_nettype none
// Rational radial plus tangential lens distortion: one normalised point in,
// one distorted point out, one item per clock unless the output stalls. The
// pipeline depth is set mostly by the divider, which resolves one quotient
// bit per stage over 64 + FRAC_BITS stages (default format Q3.28); each
// fixed-point multiplier takes MUL_LAT = 5 stages. A stall on the output
// freezes the whole pipeline, so nothing is lost or repeated. Coefficients
// must be written through the register port only while the block holds no
// items; the block does not enforce this. Indexes beyond the eighth register
// are ignored. Status reads 1 when any intermediate or the final result was
// clamped, 2 when the radial denominator was zero.
module rational_lens_distortion #(
    parameter int FRAC_BITS = rld_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  rld_pkg::t_pt_in                 i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output rld_pkg::t_pt_out                o_data,
    input  logic                            i_cfg_we,
    input  logic [rld_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rld_pkg::COEF_W-1:0]      i_cfg_data
);

    localparam int IW  = rld_pkg::IW;
    localparam int CW  = rld_pkg::COORD_W;
    localparam int KW  = rld_pkg::COEF_W;
    localparam int M   = rld_pkg::MUL_LAT;
    localparam int DL  = IW + FRAC_BITS + 3;
    localparam int P2  = M + 1;
    localparam int P3  = M + 2;
    localparam int P4  = 2*M + 1;
    localparam int P5  = 2*M + 2;
    localparam int P6  = 3*M + 1;
    localparam int P7  = 3*M + 2;
    localparam int P8  = 4*M + 1;
    localparam int P9  = 4*M + 2;
    localparam int P10 = P9 + DL;
    localparam int P11 = P10 + M;
    localparam int P13 = P11 + 2;
    localparam int P14 = P13 + 1;

    localparam int REG_IDX_W = $clog2(rld_pkg::NUM_REGS);
    localparam logic [REG_IDX_W-1:0] REG_RAD_NUM_1 = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_RAD_NUM_2 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_RAD_NUM_3 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_RAD_DEN_1 = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_RAD_DEN_2 = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_RAD_DEN_3 = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_TAN_1     = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_TAN_2     = REG_IDX_W'(7);

    localparam logic signed [IW-1:0] ONE  = IW'(1) << FRAC_BITS;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    // ---------------- control ----------------
    logic         w_en;
    logic [P14:0] r_vld;

    assign w_en    = !(r_vld[P14] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[P14];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[P14-1:0], i_valid};
        end
    end

    // ---------------- coefficients ----------------
    logic signed [KW-1:0] r_coef [0:rld_pkg::NUM_REGS-1];
    logic signed [IW-1:0] w_c_rn1, w_c_rn2, w_c_rn3, w_c_rd1, w_c_rd2, w_c_rd3;
    logic signed [IW-1:0] w_c_t1, w_c_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rld_pkg::NUM_REGS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we && i_cfg_idx < rld_pkg::CFG_IDX_W'(rld_pkg::NUM_REGS)) begin
            r_coef[i_cfg_idx[REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    assign w_c_rn1 = {{(IW-KW){r_coef[REG_RAD_NUM_1][KW-1]}}, r_coef[REG_RAD_NUM_1]};
    assign w_c_rn2 = {{(IW-KW){r_coef[REG_RAD_NUM_2][KW-1]}}, r_coef[REG_RAD_NUM_2]};
    assign w_c_rn3 = {{(IW-KW){r_coef[REG_RAD_NUM_3][KW-1]}}, r_coef[REG_RAD_NUM_3]};
    assign w_c_rd1 = {{(IW-KW){r_coef[REG_RAD_DEN_1][KW-1]}}, r_coef[REG_RAD_DEN_1]};
    assign w_c_rd2 = {{(IW-KW){r_coef[REG_RAD_DEN_2][KW-1]}}, r_coef[REG_RAD_DEN_2]};
    assign w_c_rd3 = {{(IW-KW){r_coef[REG_RAD_DEN_3][KW-1]}}, r_coef[REG_RAD_DEN_3]};
    assign w_c_t1  = {{(IW-KW){r_coef[REG_TAN_1][KW-1]}}, r_coef[REG_TAN_1]};
    assign w_c_t2  = {{(IW-KW){r_coef[REG_TAN_2][KW-1]}}, r_coef[REG_TAN_2]};

    // ---------------- input register ----------------
    logic signed [IW-1:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x <= {{(IW-CW){i_data.x_in[CW-1]}}, i_data.x_in};
            r_y <= {{(IW-CW){i_data.y_in[CW-1]}}, i_data.y_in};
        end
    end

    // ---------------- squares and cross term ----------------
    logic signed [IW-1:0] w_xx, w_yy, w_xy;
    logic                 w_xx_sat, w_yy_sat, w_xy_sat;

    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_xx (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_x), .i_b(r_x), .o_p(w_xx), .o_sat(w_xx_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_yy (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_y), .i_b(r_y), .o_p(w_yy), .o_sat(w_yy_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_xy (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_x), .i_b(r_y), .o_p(w_xy), .o_sat(w_xy_sat));

    rld_pkg::t_sum        w_r2_s, w_a1_s, w_xx2_s, w_yy2_s, w_tx_s, w_ty_s;
    logic signed [IW-1:0] r_r2, r_a1, r_xx2, r_yy2, r_tx, r_ty;
    logic                 r_sat2, r_sat3;

    assign w_r2_s  = rld_pkg::sadd(w_xx, w_yy);
    assign w_a1_s  = rld_pkg::sadd(w_xy, w_xy);
    assign w_xx2_s = rld_pkg::sadd(w_xx, w_xx);
    assign w_yy2_s = rld_pkg::sadd(w_yy, w_yy);
    assign w_tx_s  = rld_pkg::sadd(r_r2, r_xx2);
    assign w_ty_s  = rld_pkg::sadd(r_r2, r_yy2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2   <= w_r2_s.val;
            r_a1   <= w_a1_s.val;
            r_xx2  <= w_xx2_s.val;
            r_yy2  <= w_yy2_s.val;
            r_sat2 <= w_xx_sat | w_yy_sat | w_xy_sat | w_r2_s.sat | w_a1_s.sat
                    | w_xx2_s.sat | w_yy2_s.sat;
            r_tx   <= w_tx_s.val;
            r_ty   <= w_ty_s.val;
            r_sat3 <= r_sat2 | w_tx_s.sat | w_ty_s.sat;
        end
    end

    // ---------------- r^4 and first radial terms ----------------
    logic signed [IW-1:0] w_r4, w_p1n, w_p1d, w_r2_d4;
    logic                 w_r4_sat, w_p1n_sat, w_p1d_sat, w_sat3_d;

    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_r4 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_r2), .i_b(r_r2), .o_p(w_r4), .o_sat(w_r4_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_p1n (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_c_rn1), .i_b(r_r2), .o_p(w_p1n),
        .o_sat(w_p1n_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_p1d (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_c_rd1), .i_b(r_r2), .o_p(w_p1d),
        .o_sat(w_p1d_sat));

    rld_delay #(.W(IW), .N(P4-P2)) u_d_r2 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_r2), .o_q(w_r2_d4));
    rld_delay #(.W(1), .N(P4-P3)) u_d_sat3 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_sat3), .o_q(w_sat3_d));

    rld_pkg::t_sum        w_s1n_s, w_s1d_s;
    logic signed [IW-1:0] r_s1n, r_s1d;
    logic                 r_sat5;

    assign w_s1n_s = rld_pkg::sadd(ONE, w_p1n);
    assign w_s1d_s = rld_pkg::sadd(ONE, w_p1d);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1n  <= w_s1n_s.val;
            r_s1d  <= w_s1d_s.val;
            r_sat5 <= w_sat3_d | w_r4_sat | w_p1n_sat | w_p1d_sat
                    | w_s1n_s.sat | w_s1d_s.sat;
        end
    end

    // ---------------- r^6 and second radial terms ----------------
    logic signed [IW-1:0] w_r6, w_p2n, w_p2d, w_s1n_d, w_s1d_d;
    logic                 w_r6_sat, w_p2n_sat, w_p2d_sat, w_sat5_d;

    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_r6 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_r4), .i_b(w_r2_d4), .o_p(w_r6),
        .o_sat(w_r6_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_p2n (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_c_rn2), .i_b(w_r4), .o_p(w_p2n),
        .o_sat(w_p2n_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_p2d (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_c_rd2), .i_b(w_r4), .o_p(w_p2d),
        .o_sat(w_p2d_sat));

    rld_delay #(.W(IW), .N(P6-P5)) u_d_s1n (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_s1n), .o_q(w_s1n_d));
    rld_delay #(.W(IW), .N(P6-P5)) u_d_s1d (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_s1d), .o_q(w_s1d_d));
    rld_delay #(.W(1), .N(P6-P5)) u_d_sat5 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_sat5), .o_q(w_sat5_d));

    rld_pkg::t_sum        w_s2n_s, w_s2d_s;
    logic signed [IW-1:0] r_s2n, r_s2d;
    logic                 r_sat7;

    assign w_s2n_s = rld_pkg::sadd(w_s1n_d, w_p2n);
    assign w_s2d_s = rld_pkg::sadd(w_s1d_d, w_p2d);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2n  <= w_s2n_s.val;
            r_s2d  <= w_s2d_s.val;
            r_sat7 <= w_sat5_d | w_r6_sat | w_p2n_sat | w_p2d_sat
                    | w_s2n_s.sat | w_s2d_s.sat;
        end
    end

    // ---------------- third radial terms, numerator and denominator ----------------
    logic signed [IW-1:0] w_p3n, w_p3d, w_s2n_d, w_s2d_d;
    logic                 w_p3n_sat, w_p3d_sat, w_sat7_d;

    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_p3n (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_c_rn3), .i_b(w_r6), .o_p(w_p3n),
        .o_sat(w_p3n_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_p3d (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_c_rd3), .i_b(w_r6), .o_p(w_p3d),
        .o_sat(w_p3d_sat));

    rld_delay #(.W(IW), .N(P8-P7)) u_d_s2n (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_s2n), .o_q(w_s2n_d));
    rld_delay #(.W(IW), .N(P8-P7)) u_d_s2d (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_s2d), .o_q(w_s2d_d));
    rld_delay #(.W(1), .N(P8-P7)) u_d_sat7 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_sat7), .o_q(w_sat7_d));

    rld_pkg::t_sum        w_num_s, w_den_s;
    logic signed [IW-1:0] r_num, r_den;
    logic                 r_sat9;

    assign w_num_s = rld_pkg::sadd(w_s2n_d, w_p3n);
    assign w_den_s = rld_pkg::sadd(w_s2d_d, w_p3d);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num  <= w_num_s.val;
            r_den  <= w_den_s.val;
            r_sat9 <= w_sat7_d | w_p3n_sat | w_p3d_sat | w_num_s.sat | w_den_s.sat;
        end
    end

    // ---------------- radial quotient ----------------
    logic signed [IW-1:0] w_q;
    logic                 w_q_sat;

    rld_qdiv #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_num), .i_den(r_den), .o_q(w_q),
        .o_sat(w_q_sat));

    // Operands that wait for the quotient.
    logic signed [IW-1:0] w_x10, w_y10, w_a1_10, w_tx10, w_ty10;
    logic [1:0]           w_dz_d;
    logic [1:0]           w_xy_neg_d;
    logic                 w_sat9_d, w_q_sat_d;

    rld_delay #(.W(IW), .N(P10)) u_d_x (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_x), .o_q(w_x10));
    rld_delay #(.W(IW), .N(P10)) u_d_y (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_y), .o_q(w_y10));
    rld_delay #(.W(IW), .N(P10-P2)) u_d_a1 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_a1), .o_q(w_a1_10));
    rld_delay #(.W(IW), .N(P10-P3)) u_d_tx (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_tx), .o_q(w_tx10));
    rld_delay #(.W(IW), .N(P10-P3)) u_d_ty (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_ty), .o_q(w_ty10));
    rld_delay #(.W(2), .N(P13-P9)) u_d_dz (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_den == '0, r_num[IW-1]}), .o_q(w_dz_d));
    rld_delay #(.W(2), .N(P13-P10)) u_d_xy_neg (
        .i_clk(i_clk), .i_en(w_en), .i_d({w_x10[IW-1], w_y10[IW-1]}), .o_q(w_xy_neg_d));
    rld_delay #(.W(1), .N(P11-P9)) u_d_sat9 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_sat9), .o_q(w_sat9_d));
    rld_delay #(.W(1), .N(P11-P10)) u_d_q_sat (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_q_sat), .o_q(w_q_sat_d));

    // ---------------- final products ----------------
    logic signed [IW-1:0] w_xq, w_yq, w_xt1, w_xt2, w_yt1, w_yt2;
    logic                 w_xq_sat, w_yq_sat, w_xt1_sat, w_xt2_sat, w_yt1_sat, w_yt2_sat;

    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_xq (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_x10), .i_b(w_q), .o_p(w_xq), .o_sat(w_xq_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_yq (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_y10), .i_b(w_q), .o_p(w_yq), .o_sat(w_yq_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_xt1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_c_t1), .i_b(w_a1_10), .o_p(w_xt1),
        .o_sat(w_xt1_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_xt2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_c_t2), .i_b(w_tx10), .o_p(w_xt2),
        .o_sat(w_xt2_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_yt1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_c_t2), .i_b(w_a1_10), .o_p(w_yt1),
        .o_sat(w_yt1_sat));
    rld_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_yt2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_c_t1), .i_b(w_ty10), .o_p(w_yt2),
        .o_sat(w_yt2_sat));

    rld_pkg::t_sum        w_sx_s, w_sy_s, w_xd_s, w_yd_s;
    logic signed [IW-1:0] r_sx, r_sy, r_t2x, r_t2y, r_xd, r_yd;
    logic                 r_sat12, r_sat13;

    assign w_sx_s = rld_pkg::sadd(w_xq, w_xt1);
    assign w_sy_s = rld_pkg::sadd(w_yq, w_yt1);
    assign w_xd_s = rld_pkg::sadd(r_sx, r_t2x);
    assign w_yd_s = rld_pkg::sadd(r_sy, r_t2y);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx    <= w_sx_s.val;
            r_sy    <= w_sy_s.val;
            r_t2x   <= w_xt2;
            r_t2y   <= w_yt2;
            r_sat12 <= w_sat9_d | w_q_sat_d | w_xq_sat | w_yq_sat | w_xt1_sat | w_xt2_sat
                     | w_yt1_sat | w_yt2_sat | w_sx_s.sat | w_sy_s.sat;
            r_xd    <= w_xd_s.val;
            r_yd    <= w_yd_s.val;
            r_sat13 <= r_sat12 | w_xd_s.sat | w_yd_s.sat;
        end
    end

    // ---------------- output stage ----------------
    logic             w_x_fit, w_y_fit;
    rld_pkg::t_pt_out n_out, r_out;

    always_comb begin
        // A value fits the coordinate width when its upper bits are all sign.
        w_x_fit = (~|r_xd[IW-1:CW-1]) || (&r_xd[IW-1:CW-1]);
        w_y_fit = (~|r_yd[IW-1:CW-1]) || (&r_yd[IW-1:CW-1]);
        if (w_dz_d[1]) begin
            // Zero denominator: push towards the side given by the point and numerator.
            n_out.x_out  = (w_xy_neg_d[1] == w_dz_d[0]) ? CMAX : CMIN;
            n_out.y_out  = (w_xy_neg_d[0] == w_dz_d[0]) ? CMAX : CMIN;
            n_out.status = rld_pkg::ST_DEN_ZERO;
        end else begin
            n_out.x_out  = w_x_fit ? r_xd[CW-1:0] : (r_xd[IW-1] ? CMIN : CMAX);
            n_out.y_out  = w_y_fit ? r_yd[CW-1:0] : (r_yd[IW-1] ? CMIN : CMAX);
            n_out.status = (r_sat13 || !w_x_fit || !w_y_fit) ? rld_pkg::ST_SAT
                                                             : rld_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

    // ---------------- assertions ----------------
    a_freeze_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline moved while the output was stalled");

    a_r2_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[P2] |-> !r_r2[IW-1])
        else $error("r squared went negative");

    a_r4_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[P4] && w_r4_sat) |-> (w_r4 == rld_pkg::IMAX))
        else $error("clamped r^4 is not the largest value");

    a_q_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[P10] && w_q_sat) |-> (w_q == rld_pkg::IMAX || w_q == -rld_pkg::IMAX))
        else $error("clamped quotient is not at full scale");

    a_dz_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == rld_pkg::ST_DEN_ZERO)
        |-> ((o_data.x_out == CMAX || o_data.x_out == CMIN)
             && (o_data.y_out == CMAX || o_data.y_out == CMIN)))
        else $error("zero denominator result is not at full scale");

endmodule
`default_nettype wire
